>>> sv/hb_pkg.sv
package hb_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int POS_W          = 6;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 32;

    // register index, taken from paddr[2]
    localparam logic REG_HEAP_KIND = 1'b0;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_KIDS,
        S_CMP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_HOLD
    } t_state;

    typedef struct packed {
        logic take;
        logic fetch;
        logic kids;
        logic cmp;
        logic step_node;
        logic emit_rd;
        logic emit_load;
        logic emit_next;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic final_fire;
        logic has_inner;
        logic moved;
        logic idx_zero;
        logic out_fire;
        logic last_emit;
    } t_status;

endpackage

>>> sv/hb_if.sv
interface hb_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [hb_pkg::VALUE_W-1:0]  value;
    logic                               final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface hb_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [hb_pkg::VALUE_W-1:0]  heap_value;
    logic [hb_pkg::POS_W-1:0]           position;
    logic                               end_of_run;
    logic                               overflowed;

    modport source (output valid, output heap_value, output position, output end_of_run,
                    output overflowed, input ready);
    modport sink   (input valid, input heap_value, input position, input end_of_run,
                    input overflowed, output ready);
endinterface

>>> sv/hb_ram.sv
module hb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sv/hb_ctrl.sv
module hb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hb_pkg::t_status i_status,
    output hb_pkg::t_cmd    o_cmd
);
    import hb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_status.final_fire) begin
                    n_state = i_status.has_inner ? S_FETCH : S_EMIT_RD;
                end
            end
            S_FETCH:   n_state = S_KIDS;
            S_KIDS:    n_state = S_CMP;
            S_CMP: begin
                priority if (i_status.moved) begin
                    n_state = S_KIDS;
                end else if (i_status.idx_zero) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: n_state = S_EMIT_HOLD;
            S_EMIT_HOLD: begin
                if (i_status.out_fire) begin
                    n_state = i_status.last_emit ? S_LOAD : S_EMIT_RD;
                end
            end
            default:   n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_LOAD:    o_cmd.take = 1'b1;
            S_FETCH:   o_cmd.fetch = 1'b1;
            S_KIDS:    o_cmd.kids = 1'b1;
            S_CMP: begin
                o_cmd.cmp       = 1'b1;
                o_cmd.step_node = !i_status.moved && !i_status.idx_zero;
            end
            S_EMIT_RD: o_cmd.emit_rd = 1'b1;
            S_EMIT_LD: o_cmd.emit_load = 1'b1;
            S_EMIT_HOLD: begin
                o_cmd.emit_next = i_status.out_fire && !i_status.last_emit;
                o_cmd.finish    = i_status.out_fire && i_status.last_emit;
            end
            default:   o_cmd = '0;
        endcase
    end

endmodule

>>> sv/hb_dpath.sv
module hb_dpath #(
    parameter int CAPACITY   = hb_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = hb_pkg::DATA_WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_heap_kind,
    input  hb_pkg::t_cmd    i_cmd,
    output hb_pkg::t_status o_status,
    hb_in_if.sink           i_in,
    hb_out_if.source        o_out
);
    import hb_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = AW + 2;

    logic [CW-1:0]         r_fill;
    logic                  r_ovf;
    logic [CW-1:0]         r_n;
    logic [AW-1:0]         r_idx;
    logic [AW-1:0]         r_node;
    logic [AW-1:0]         r_k;
    logic                  r_first;
    logic [DATA_WIDTH-1:0] r_v;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_val;
    logic [POS_W-1:0]      r_out_pos;
    logic                  r_out_end;
    logic                  r_out_ovf;

    logic                  w_in_fire;
    logic                  w_room;
    logic                  w_load_wr;
    logic [CW-1:0]         w_n_new;
    logic [CW-1:0]         w_start;
    logic [DATA_WIDTH-1:0] w_in_data;
    logic [NW-1:0]         w_l;
    logic [NW-1:0]         w_r;
    logic                  w_lv;
    logic                  w_rv;
    logic                  w_best_l;
    logic                  w_best_r;
    logic [DATA_WIDTH-1:0] w_bv;
    logic [DATA_WIDTH-1:0] w_rd_a;
    logic [DATA_WIDTH-1:0] w_rd_b;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [AW-1:0]         w_raddr_a;
    logic                  w_out_fire;
    logic                  w_last_emit;

    function automatic logic ahead(input logic kind, input logic [DATA_WIDTH-1:0] a,
                                   input logic [DATA_WIDTH-1:0] b);
        return kind ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    assign w_in_fire = i_cmd.take && i_in.valid;
    assign w_room    = r_fill < CW'(CAPACITY);
    assign w_load_wr = w_in_fire && w_room;
    assign w_n_new   = w_room ? r_fill + CW'(1) : r_fill;
    assign w_start   = (w_n_new >> 1) - CW'(1);
    assign w_in_data = DATA_WIDTH'(i_in.value);

    // children of the node being sifted
    assign w_l  = {1'b0, r_node, 1'b1};
    assign w_r  = w_l + NW'(1);
    assign w_lv = w_l < NW'(r_n);
    assign w_rv = w_r < NW'(r_n);

    // ties keep the parent, equal children give the left one
    assign w_best_l = w_lv && ahead(i_heap_kind, w_rd_a, r_v);
    assign w_bv     = w_best_l ? w_rd_a : r_v;
    assign w_best_r = w_rv && ahead(i_heap_kind, w_rd_b, w_bv);

    assign w_out_fire  = r_out_valid && o_out.ready;
    assign w_last_emit = (CW'(r_k) + CW'(1)) == r_n;

    always_comb begin
        priority if (i_cmd.fetch) begin
            w_raddr_a = r_idx;
        end else if (i_cmd.kids) begin
            w_raddr_a = AW'(w_l);
        end else if (i_cmd.emit_rd) begin
            w_raddr_a = r_k;
        end else begin
            w_raddr_a = r_idx;
        end
    end

    always_comb begin
        w_we    = w_load_wr || i_cmd.cmp;
        w_waddr = i_cmd.cmp ? r_node : AW'(r_fill);
        priority if (!i_cmd.cmp) begin
            w_wdata = w_in_data;
        end else if (w_best_r) begin
            w_wdata = w_rd_b;
        end else if (w_best_l) begin
            w_wdata = w_rd_a;
        end else begin
            w_wdata = r_v;
        end
    end

    hb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (AW'(w_r)),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_first     <= 1'b0;
        end else begin
            priority if (i_cmd.finish) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end else if (w_in_fire) begin
                if (w_room) begin
                    r_fill <= r_fill + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.fetch) begin
                r_first <= 1'b1;
            end else if (i_cmd.kids) begin
                r_first <= 1'b0;
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && i_in.final_item) begin
            r_n   <= w_n_new;
            r_idx <= AW'(w_start);
            r_k   <= '0;
        end
        if (i_cmd.step_node) begin
            r_idx <= r_idx - AW'(1);
        end
        if (i_cmd.fetch) begin
            r_node <= r_idx;
        end else if (i_cmd.cmp) begin
            if (w_best_r) begin
                r_node <= AW'(w_r);
            end else if (w_best_l) begin
                r_node <= AW'(w_l);
            end
        end
        // the sifted value is read once and written where it settles
        if (i_cmd.kids && r_first) begin
            r_v <= w_rd_a;
        end
        if (i_cmd.emit_load) begin
            r_out_val <= VALUE_W'(w_rd_a);
            r_out_pos <= POS_W'(r_k);
            r_out_end <= w_last_emit;
            r_out_ovf <= r_ovf;
        end
        if (i_cmd.emit_next) begin
            r_k <= r_k + AW'(1);
        end
    end

    assign i_in.ready        = i_cmd.take;
    assign o_out.valid       = r_out_valid;
    assign o_out.heap_value  = r_out_val;
    assign o_out.position    = r_out_pos;
    assign o_out.end_of_run  = r_out_end;
    assign o_out.overflowed  = r_out_ovf;

    assign o_status.final_fire = w_in_fire && i_in.final_item;
    assign o_status.has_inner  = w_n_new >= CW'(2);
    assign o_status.moved      = w_best_l || w_best_r;
    assign o_status.idx_zero   = r_idx == '0;
    assign o_status.out_fire   = w_out_fire;
    assign o_status.last_emit  = w_last_emit;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take |-> !r_out_valid)
        else $error("input taken while a result is pending");

    a_sift_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cmp |-> (r_n >= CW'(2)))
        else $error("sift on a set with no internal node");

    a_run_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && r_out_end) |=> (r_fill == '0 && !r_ovf))
        else $error("set state not cleared after the last item");

endmodule

>>> sv/heap_builder_core.sv
// heap builder
// input channel i_in: one signed value per item in level order; final_item marks
// the last value of a set. each value offered while the block loads is taken at once.
// values beyond CAPACITY are dropped and reported on every result of the set.
// the final item starts a bottom-up sift-down of every internal node in the store,
// building a min-heap (heap_kind 0) or a max-heap (heap_kind 1), then the heap is
// sent on o_out in level order, one item per element, end_of_run on the last.
// build: each internal node goes through a node read, the child reads, and a compare
// and write back, the child reads and compare repeating for each level a value moves
// down, since the reads of the store are registered; each result then goes through a
// store read, an output load and a handover that waits while the receiver holds ready
// low. a stalled receiver simply holds the result register; no input is taken until
// the whole heap has been delivered.
// heap_kind is written over apb at byte addresses 0 to 3 (paddr[2] clear); writes
// with paddr[2] set are ignored. reset empties the set, clears heap_kind and drops any
// pending result; the store itself is not cleared and needs no clearing pass.
module heap_builder_core #(
    parameter int CAPACITY   = hb_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = hb_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    hb_in_if.sink                         i_in,
    hb_out_if.source                      o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hb_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [hb_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [hb_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready
);
    import hb_pkg::*;

    logic    r_heap_kind;
    logic    w_reg_sel;
    t_cmd    w_cmd;
    t_status w_status;

    assign pready    = 1'b1;
    assign w_reg_sel = paddr[2] == REG_HEAP_KIND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_kind <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_heap_kind <= pwdata[0];
        end
    end

    assign prdata = w_reg_sel ? {{(CFG_DATA_W-1){1'b0}}, r_heap_kind} : '0;

    hb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    hb_dpath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_heap_kind (r_heap_kind),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

>>> tb/tb_heap_builder_core.sv
module tb_heap_builder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hb_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD  = 300;
    localparam int SETTLE     = 8;

    localparam logic [CFG_ADDR_W-1:0] KIND_ADDR     = {REG_HEAP_KIND, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = {~REG_HEAP_KIND, 2'b00};
    localparam logic MIN_HEAP = 1'b0;
    localparam logic MAX_HEAP = 1'b1;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last_one;
    } load_item_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
        logic                      last_one;
        logic                      ovf;
    } heap_entry_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    hb_in_if  in_ch ();
    hb_out_if out_ch ();

    heap_builder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predicted state of the block
    logic signed [VALUE_W-1:0] model_store [CAPACITY];
    int                        model_fill;
    logic                      model_ovf;
    logic                      model_kind;

    load_item_t  load_queue [$];
    heap_entry_t heap_expect [$];

    int          err_count;
    int          cycle_count;
    bit          in_taken;
    bit          idling_on;
    bit          hold_armed;
    int          send_gap;
    int          stall_left;
    int          hold_left;
    logic        next_valid;
    load_item_t  pend;
    heap_entry_t want;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit ranks_ahead(logic signed [VALUE_W-1:0] a,
                                       logic signed [VALUE_W-1:0] b);
        return model_kind ? (a > b) : (a < b);
    endfunction

    task automatic sift_node(int node, int n);
        int best;
        int lc;
        logic signed [VALUE_W-1:0] tmp;
        while (node < n) begin
            best = node;
            lc   = 2 * node + 1;
            // strict compares: ties keep the parent, the left child wins between equals
            if (lc < n && ranks_ahead(model_store[lc], model_store[best])) best = lc;
            if (lc + 1 < n && ranks_ahead(model_store[lc + 1], model_store[best])) best = lc + 1;
            if (best == node) break;
            tmp               = model_store[node];
            model_store[node] = model_store[best];
            model_store[best] = tmp;
            node              = best;
        end
    endtask

    task automatic absorb_value(logic signed [VALUE_W-1:0] v, logic last_one);
        int n;
        heap_entry_t e;
        if (model_fill < CAPACITY) begin
            model_store[model_fill] = v;
            model_fill++;
        end else begin
            model_ovf = 1'b1;
        end
        if (last_one) begin
            n = model_fill;
            for (int i = n - 1; i >= 0; i--) sift_node(i, n);
            for (int i = 0; i < n; i++) begin
                e.value    = model_store[i];
                e.pos      = POS_W'(i);
                e.last_one = (i == n - 1);
                e.ovf      = model_ovf;
                heap_expect.push_back(e);
            end
            model_fill = 0;
            model_ovf  = 1'b0;
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 6) - 3;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7fffffff;
                    1: v = 32'sh80000000;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic add_value(logic signed [VALUE_W-1:0] v, logic last_one);
        load_item_t it;
        it.value    = v;
        it.last_one = last_one;
        load_queue.push_back(it);
    endtask

    task automatic queue_set(int size);
        for (int i = 0; i < size; i++) add_value(pick_value(), i == size - 1);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == KIND_ADDR) model_kind = data[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits carry noise, only bit 0 matters
    task automatic set_heap_kind(logic kind);
        logic [CFG_DATA_W-1:0] data;
        data    = $urandom();
        data[0] = kind;
        write_reg(KIND_ADDR, data);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (load_queue.size() != 0 || in_ch.valid || heap_expect.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // item driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            next_valid = in_ch.valid && !in_taken;
            in_taken   = 1'b0;
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (load_queue.size() != 0) begin
                    if (idling_on && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(0, 6);
                    end else begin
                        pend = load_queue.pop_front();
                        in_ch.value      <= pend.value;
                        in_ch.final_item <= pend.last_one;
                        next_valid = 1'b1;
                    end
                end
            end
            in_ch.valid <= next_valid;
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_armed && out_ch.valid) begin
                hold_armed = 1'b0;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // monitor: feed the predictor and check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                in_taken = 1'b1;
                absorb_value(in_ch.value, in_ch.final_item);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (heap_expect.size() == 0) begin
                    $error("unexpected heap item at position %0d", out_ch.position);
                    err_count++;
                end else begin
                    want = heap_expect.pop_front();
                    if (out_ch.heap_value !== want.value) begin
                        $error("heap_value: expected %0d, got %0d", want.value,
                               out_ch.heap_value);
                        err_count++;
                    end
                    if (out_ch.position !== want.pos) begin
                        $error("position: expected %0d, got %0d", want.pos, out_ch.position);
                        err_count++;
                    end
                    if (out_ch.end_of_run !== want.last_one) begin
                        $error("end_of_run: expected %0d, got %0d", want.last_one,
                               out_ch.end_of_run);
                        err_count++;
                    end
                    if (out_ch.overflowed !== want.ovf) begin
                        $error("overflowed: expected %0d, got %0d", want.ovf,
                               out_ch.overflowed);
                        err_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int  size;
        int  random_items;
        bit  first_set;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.value      = '0;
        in_ch.final_item = 1'b0;
        out_ch.ready     = 1'b0;
        model_fill       = 0;
        model_ovf        = 1'b0;
        model_kind       = MIN_HEAP;
        err_count        = 0;
        cycle_count      = 0;
        in_taken         = 1'b0;
        idling_on        = 1'b1;
        hold_armed       = 1'b0;
        send_gap         = 0;
        stall_left       = 0;
        hold_left        = 0;
        random_items     = 0;
        first_set        = 1'b1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes and duplicates, min-heap
        set_heap_kind(MIN_HEAP);
        add_value(32'sh7fffffff, 1'b0); add_value(32'sh80000000, 1'b0);
        add_value(32'sh00000000, 1'b0); add_value(-32'sd1, 1'b0);
        add_value(32'sh7fffffff, 1'b0); add_value(32'sh80000000, 1'b1);
        // single value set
        add_value(-32'sd5, 1'b1);
        wait_idle();

        // all equal: parent stays put
        set_heap_kind(MAX_HEAP);
        add_value(32'sd3, 1'b0); add_value(32'sd3, 1'b0); add_value(32'sd3, 1'b0);
        add_value(32'sd3, 1'b0); add_value(32'sd3, 1'b1);
        // equal children: left wins
        add_value(32'sd1, 1'b0); add_value(32'sd5, 1'b0); add_value(32'sd5, 1'b0);
        add_value(32'sd2, 1'b0); add_value(32'sd2, 1'b0); add_value(32'sd4, 1'b0);
        add_value(32'sd4, 1'b1);
        wait_idle();

        // a write to an unmapped address leaves the max-heap setting alone
        write_reg(UNMAPPED_ADDR, '0);
        add_value(32'sh80000000, 1'b0); add_value(32'sh7fffffff, 1'b0);
        add_value(32'sh80000000, 1'b1);
        wait_idle();

        set_heap_kind(MIN_HEAP);
        add_value(32'sd9, 1'b0); add_value(32'sd4, 1'b0); add_value(32'sd4, 1'b1);
        wait_idle();

        // receiver backs off while the next set is already offered
        hold_armed = 1'b1;
        queue_set(20);
        queue_set(20);
        wait_idle();

        while (random_items < 135) begin
            if (random_items >= 100) idling_on = 1'b0;
            else idling_on = ($urandom_range(0, 3) != 0);
            if (first_set) size = CAPACITY + 2;
            else if ($urandom_range(0, 11) == 0) size = $urandom_range(50, CAPACITY + 4);
            else size = $urandom_range(1, 12);
            first_set = 1'b0;
            set_heap_kind(1'($urandom_range(0, 1)));
            queue_set(size);
            random_items += size;
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && heap_expect.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
